[hdl/rsi_pkg.sv]
// Shared types and constants for the ray-sphere intersection block.
// Used by rsi_quad, rsi_div, rsi_fifo and the top level; depends on nothing else.
package rsi_pkg;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        CMD_LOAD      = 1'b0,
        CMD_INTERSECT = 1'b1
    } cmd_t;

    // Fixed-point and datapath widths.
    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 31;
    localparam int INDEX_W   = 10;
    localparam int A_W       = 48;   // |d|^2 after truncation
    localparam int BC_W      = 51;   // signed b and c
    localparam int DISC_W    = 102;  // discriminant in Q70.32, padded to an even width
    localparam int ROOT_W    = DISC_W / 2;
    localparam int DIV_W     = 52;   // divider operand magnitudes
    localparam int FRAC_W    = 16;
    localparam int QSAT_LOG  = 33;   // quotient magnitude saturates to 2^33
    localparam int QT_W      = QSAT_LOG + 2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

    // Output queue behind the pipeline; it must exceed the pipeline latency.
    localparam int FIFO_AW    = 7;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Saturation limits of hit_t.
    localparam logic signed [QT_W-1:0] T_MAX32 = 35'sd2147483647;
    localparam logic signed [QT_W-1:0] T_MIN32 = -35'sd2147483648;

    // Per-item side information that rides along with the arithmetic.
    typedef struct packed {
        logic               live;   // still a candidate for a hit
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
    } rsi_side_t;

    // Quadratic coefficients.
    typedef struct packed {
        logic signed [BC_W-1:0] b;
        logic signed [BC_W-1:0] c;
        logic [A_W-1:0]         a;
    } rsi_coef_t;

    // Tag carried through the square root pipeline.
    typedef struct packed {
        rsi_side_t side;
        rsi_coef_t coef;
    } rsi_sq_tag_t;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_t;
    } rsi_result_t;

endpackage

[hdl/rsi_mul.sv]
// Two-stage unsigned multiplier built from four half-width partial products.
// Uses no package items; instantiated by rsi_quad.
module rsi_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               aclk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);
    localparam int AL = A_W / 2;
    localparam int AH = A_W - AL;
    localparam int BL = B_W / 2;
    localparam int BH = B_W - BL;
    localparam int PW = A_W + B_W;

    logic [AL+BL-1:0] pll_reg;
    logic [AL+BH-1:0] plh_reg;
    logic [AH+BL-1:0] phl_reg;
    logic [AH+BH-1:0] phh_reg;
    logic [PW-1:0]    p_reg;

    // First stage: partial products.
    always_ff @(posedge aclk) begin
        pll_reg <= a[AL-1:0]   * b[BL-1:0];
        plh_reg <= a[AL-1:0]   * b[B_W-1:BL];
        phl_reg <= a[A_W-1:AL] * b[BL-1:0];
        phh_reg <= a[A_W-1:AL] * b[B_W-1:BL];
    end

    // Second stage: weighted sum.
    always_ff @(posedge aclk) begin
        p_reg <= PW'(pll_reg) + (PW'(plh_reg) << BL) + (PW'(phl_reg) << AL)
                 + (PW'(phh_reg) << (AL + BL));
    end

    assign p = p_reg;

endmodule

[hdl/rsi_quad.sv]
// Center store and quadratic setup: a, b, c and the discriminant.
// Depends on rsi_pkg and rsi_mul.
module rsi_quad import rsi_pkg::*; #(
    parameter int SPHERE_COUNT = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  cmd_t                       in_cmd,
    input  logic [INDEX_W-1:0]         in_index,
    input  logic signed [COORD_W-1:0]  in_point [3],
    input  logic signed [COORD_W-1:0]  in_dir [3],
    input  logic signed [31:0]         in_t_min,
    input  logic signed [31:0]         in_t_max,
    input  logic [RADIUS_W-1:0]        radius,
    output logic                       out_valid,
    output rsi_sq_tag_t                out_tag,
    output logic [DISC_W-1:0]          out_disc
);
    localparam int AW = (SPHERE_COUNT > 1) ? $clog2(SPHERE_COUNT) : 1;

    logic [95:0] center_mem [SPHERE_COUNT];

    logic [AW+INDEX_W-1:0] idx_ext;
    logic [AW-1:0]         addr;
    logic                  in_range;

    // Stage 0: store access.
    logic               v0_reg;
    rsi_side_t          side0_reg;
    logic signed [31:0] pt0_reg [3];
    logic signed [31:0] dir0_reg [3];
    logic [95:0]        ctr_reg;

    // Stage 1: magnitudes of d and o-c.
    logic               v1_reg, v2_reg, v3_reg;
    rsi_side_t          side1_reg, side2_reg, side3_reg;
    logic [31:0]        dm1_reg [3];
    logic [32:0]        om1_reg [3];
    logic [2:0]         dneg1_reg, dneg2_reg, dneg3_reg;
    logic [2:0]         oneg1_reg, oneg2_reg, oneg3_reg;
    logic [RADIUS_W-1:0] rad1_reg;
    logic signed [32:0] oc [3];

    // Products.
    logic [63:0] dd [3];
    logic [64:0] doc [3];
    logic [65:0] oo [3];
    logic [61:0] rr;

    // Stage 4: coefficients.
    logic               v4_reg, v5_reg, v6_reg, v7_reg;
    rsi_side_t          side4_reg, side5_reg, side6_reg;
    rsi_coef_t          coef4_reg, coef5_reg, coef6_reg;
    rsi_coef_t          coef_next;
    logic               live4_next;
    logic [A_W-1:0]     a_sum;
    logic signed [49:0] h_sum;
    logic [50:0]        c_pos;
    logic signed [49:0] h_term [3];

    // Stage 5 to 7: discriminant.
    logic [49:0]        b_mag, c_mag;
    logic [99:0]        bb;
    logic [97:0]        ac;
    logic [99:0]        ac4;
    logic               c_neg;
    rsi_sq_tag_t        tag7_reg;
    logic [DISC_W-1:0]  disc7_reg;
    rsi_side_t          side7_next;

    assign idx_ext  = {AW'(0), in_index};
    assign addr     = idx_ext[AW-1:0];
    assign in_range = idx_ext < (AW+INDEX_W)'(SPHERE_COUNT);

    // Center store: an in-range load writes, every transfer reads its entry.
    always_ff @(posedge aclk) begin
        if (in_valid && in_range && in_cmd == CMD_LOAD) begin
            center_mem[addr] <= {in_point[2], in_point[1], in_point[0]};
        end
        ctr_reg <= center_mem[addr];
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Stage 0 capture of the item.
    always_ff @(posedge aclk) begin
        side0_reg.live  <= (in_cmd == CMD_INTERSECT) && in_range;
        side0_reg.t_min <= in_t_min;
        side0_reg.t_max <= in_t_max;
        for (int k = 0; k < 3; k++) begin
            pt0_reg[k]  <= in_point[k];
            dir0_reg[k] <= in_dir[k];
        end
    end

    // Stage 1: o-c and sign/magnitude split.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            oc[k] = 33'(pt0_reg[k]) - 33'(signed'(ctr_reg[32*k +: 32]));
        end
    end

    always_ff @(posedge aclk) begin
        side1_reg <= side0_reg;
        rad1_reg  <= radius;
        for (int k = 0; k < 3; k++) begin
            dneg1_reg[k] <= dir0_reg[k][31];
            oneg1_reg[k] <= oc[k][32];
            dm1_reg[k]   <= dir0_reg[k][31] ? 32'(-dir0_reg[k]) : 32'(dir0_reg[k]);
            om1_reg[k]   <= oc[k][32] ? 33'(-oc[k]) : 33'(oc[k]);
        end
    end

    // Products of the first multiply level.
    for (genvar k = 0; k < 3; k++) begin : g_lane
        rsi_mul #(.A_W(32), .B_W(32)) u_dd (
            .aclk (aclk), .a (dm1_reg[k]), .b (dm1_reg[k]), .p (dd[k])
        );
        rsi_mul #(.A_W(32), .B_W(33)) u_doc (
            .aclk (aclk), .a (dm1_reg[k]), .b (om1_reg[k]), .p (doc[k])
        );
        rsi_mul #(.A_W(33), .B_W(33)) u_oo (
            .aclk (aclk), .a (om1_reg[k]), .b (om1_reg[k]), .p (oo[k])
        );
    end

    rsi_mul #(.A_W(RADIUS_W), .B_W(RADIUS_W)) u_rr (
        .aclk (aclk), .a (rad1_reg), .b (rad1_reg), .p (rr)
    );

    // Side data waits for the multipliers.
    always_ff @(posedge aclk) begin
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        dneg2_reg <= dneg1_reg;
        dneg3_reg <= dneg2_reg;
        oneg2_reg <= oneg1_reg;
        oneg3_reg <= oneg2_reg;
    end

    // Stage 4: truncate the products and sum them into a, b and c.
    always_comb begin
        a_sum = '0;
        h_sum = '0;
        c_pos = '0;
        for (int k = 0; k < 3; k++) begin
            h_term[k] = (dneg3_reg[k] ^ oneg3_reg[k]) ? -50'(doc[k][64:16])
                                                       : 50'(doc[k][64:16]);
            a_sum = a_sum + A_W'(dd[k][63:16]);
            h_sum = h_sum + h_term[k];
            c_pos = c_pos + 51'(oo[k][65:16]);
        end
        coef_next.a = a_sum;
        coef_next.b = {h_sum, 1'b0};
        coef_next.c = signed'(c_pos) - signed'(51'(rr[61:16]));
        live4_next  = side3_reg.live && (a_sum != '0);
    end

    always_ff @(posedge aclk) begin
        side4_reg.live  <= live4_next;
        side4_reg.t_min <= side3_reg.t_min;
        side4_reg.t_max <= side3_reg.t_max;
        coef4_reg       <= coef_next;
    end

    // Second multiply level: b^2 and a*|c|.
    assign b_mag = coef4_reg.b[BC_W-1] ? 50'(-coef4_reg.b) : 50'(coef4_reg.b);
    assign c_mag = coef4_reg.c[BC_W-1] ? 50'(-coef4_reg.c) : 50'(coef4_reg.c);

    rsi_mul #(.A_W(50), .B_W(50)) u_bb (
        .aclk (aclk), .a (b_mag), .b (b_mag), .p (bb)
    );
    rsi_mul #(.A_W(A_W), .B_W(50)) u_ac (
        .aclk (aclk), .a (coef4_reg.a), .b (c_mag), .p (ac)
    );

    always_ff @(posedge aclk) begin
        side5_reg <= side4_reg;
        side6_reg <= side5_reg;
        coef5_reg <= coef4_reg;
        coef6_reg <= coef5_reg;
    end

    // Stage 7: discriminant, miss when it is negative.
    assign ac4   = {ac, 2'b00};
    assign c_neg = coef6_reg.c[BC_W-1];

    always_comb begin
        side7_next      = side6_reg;
        side7_next.live = side6_reg.live && (c_neg || !(bb < ac4));
    end

    always_ff @(posedge aclk) begin
        tag7_reg.side <= side7_next;
        tag7_reg.coef <= coef6_reg;
        disc7_reg     <= c_neg ? (DISC_W'(bb) + DISC_W'(ac4)) : (DISC_W'(bb) - DISC_W'(ac4));
    end

    assign out_valid = v7_reg;
    assign out_tag   = tag7_reg;
    assign out_disc  = disc7_reg;

endmodule

[hdl/rsi_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Uses no package items; instantiated by the top level.
module rsi_sqrt #(
    parameter int RAD_W = 102,
    parameter int TAG_W = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [RAD_W-1:0]   in_rad,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [RAD_W/2-1:0] out_root,
    output logic [TAG_W-1:0]   out_tag
);
    localparam int ITER  = RAD_W / 2;
    localparam int REM_W = ITER + 2;

    logic [ITER-1:0]  v_reg;
    logic [RAD_W-1:0] rad_reg [ITER];
    logic [REM_W-1:0] rem_reg [ITER];
    logic [ITER-1:0]  res_reg [ITER];
    logic [TAG_W-1:0] tag_reg [ITER];

    logic [RAD_W-1:0] rad_next [ITER];
    logic [REM_W-1:0] rem_next [ITER];
    logic [ITER-1:0]  res_next [ITER];

    // One restoring step per stage on the next pair of radicand bits.
    always_comb begin
        logic [RAD_W-1:0] cur_rad;
        logic [REM_W-1:0] cur_rem;
        logic [ITER-1:0]  cur_res;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < ITER; k++) begin
            if (k == 0) begin
                cur_rad = in_rad;
                cur_rem = '0;
                cur_res = '0;
            end else begin
                cur_rad = rad_reg[k-1];
                cur_rem = rem_reg[k-1];
                cur_res = res_reg[k-1];
            end
            rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1:RAD_W-2]};
            trial  = {cur_res, 2'b01};
            if (rem_sh >= trial) begin
                rem_next[k] = rem_sh - trial;
                res_next[k] = {cur_res[ITER-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_sh;
                res_next[k] = {cur_res[ITER-2:0], 1'b0};
            end
            rad_next[k] = cur_rad << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[ITER-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ITER; k++) begin
            rad_reg[k] <= rad_next[k];
            rem_reg[k] <= rem_next[k];
            res_reg[k] <= res_next[k];
            if (k == 0) begin
                tag_reg[k] <= in_tag;
            end else begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ITER-1];
    assign out_root  = res_reg[ITER-1];
    assign out_tag   = tag_reg[ITER-1];

endmodule

[hdl/rsi_div.sv]
// Pipelined restoring divider giving num*2^16/den, truncated and saturated.
// Depends on rsi_pkg; instantiated by the top level.
module rsi_div import rsi_pkg::*; #(
    parameter int N_W   = 52,
    parameter int D_W   = 52,
    parameter int TAG_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [N_W-1:0]         in_num,
    input  logic [D_W-1:0]         in_den,
    input  logic                   in_neg,
    input  logic [TAG_W-1:0]       in_tag,
    output logic                   out_valid,
    output logic signed [QT_W-1:0] out_q,
    output logic [TAG_W-1:0]       out_tag
);
    localparam int NS    = N_W + FRAC_W;
    localparam int DS    = D_W + QSAT_LOG;
    localparam int R_W   = (NS > DS) ? NS : DS;
    localparam int STEPS = QSAT_LOG;

    logic [STEPS:0]        v_reg;
    logic [R_W-1:0]        rem_reg [STEPS+1];
    logic [D_W-1:0]        den_reg [STEPS+1];
    logic [QSAT_LOG-1:0]   q_reg   [STEPS+1];
    logic [STEPS:0]        sat_reg;
    logic [STEPS:0]        neg_reg;
    logic [TAG_W-1:0]      tag_reg [STEPS+1];

    logic [R_W-1:0]        rem_next [STEPS+1];
    logic [QSAT_LOG-1:0]   q_next   [STEPS+1];
    logic                  sat0_next;

    logic                  vo_reg;
    logic signed [QT_W-1:0] q_out_reg;
    logic [TAG_W-1:0]      tag_out_reg;
    logic [QT_W-1:0]       q_mag;

    // Setup checks saturation, then each stage settles one quotient bit.
    always_comb begin
        logic [R_W-1:0] trial;
        rem_next[0] = R_W'(in_num) << FRAC_W;
        q_next[0]   = '0;
        sat0_next   = rem_next[0] >= (R_W'(in_den) << QSAT_LOG);
        for (int j = 1; j <= STEPS; j++) begin
            trial       = R_W'(den_reg[j-1]) << (STEPS - j);
            rem_next[j] = rem_reg[j-1];
            q_next[j]   = q_reg[j-1];
            if (rem_reg[j-1] >= trial) begin
                rem_next[j]           = rem_reg[j-1] - trial;
                q_next[j][STEPS - j]  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end else begin
            v_reg  <= {v_reg[STEPS-1:0], in_valid};
            vo_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j <= STEPS; j++) begin
            rem_reg[j] <= rem_next[j];
            q_reg[j]   <= q_next[j];
            if (j == 0) begin
                den_reg[j] <= in_den;
                sat_reg[j] <= sat0_next;
                neg_reg[j] <= in_neg;
                tag_reg[j] <= in_tag;
            end else begin
                den_reg[j] <= den_reg[j-1];
                sat_reg[j] <= sat_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    // Apply saturation and sign.
    assign q_mag = sat_reg[STEPS] ? (QT_W'(1) << QSAT_LOG) : QT_W'(q_reg[STEPS]);

    always_ff @(posedge aclk) begin
        q_out_reg   <= neg_reg[STEPS] ? -signed'(q_mag) : signed'(q_mag);
        tag_out_reg <= tag_reg[STEPS];
    end

    assign out_valid = vo_reg;
    assign out_q     = q_out_reg;
    assign out_tag   = tag_out_reg;

endmodule

[hdl/rsi_fifo.sv]
// Result queue with a registered output stage feeding the master channel.
// Depends on rsi_pkg for the result type and depth.
module rsi_fifo import rsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_valid,
    input  rsi_result_t wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsi_result_t out_data
);
    rsi_result_t         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    rsi_result_t         out_data_reg;
    logic                pop;

    // Refill the output stage from a non-empty queue whenever it is empty or being taken.
    assign pop = (cnt_reg != '0) && (!out_valid_reg || out_ready);

    always_comb begin
        cnt_next = cnt_reg + (FIFO_AW+1)'(wr_valid) - (FIFO_AW+1)'(pop);
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Queue storage with registered read.
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (pop) begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pop reads the slot being written in the same cycle only when the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop && wr_valid |-> rd_ptr_reg != wr_ptr_reg || cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue read collides with write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> out_valid_reg)
        else $error("output stage not loaded after pop");

endmodule

[hdl/ray_sphere_intersect.sv]
// Top level of the ray-sphere intersection block: config, credit control,
// root and quotient stages. Depends on rsi_pkg, rsi_quad, rsi_sqrt, rsi_div, rsi_fifo.
//
//  Channel   Direction  Contents
//  s_*       in         tuser: command; tdata: index, point xyz, dir xyz, t_min, t_max
//  m_*       out        tuser: hit; tdata: hit_t
//  cfg_*     in         sphere_radius write
//
// One item is accepted every cycle while s_tready is high; the path from input transfer to
// m_tvalid runs through the 51-stage square root and the 35-stage dividers.
// Reset is synchronous, active low; the center store is not cleared.
// Up to 128 items may be in flight; s_tready drops only when that many results
// are accepted but not yet transferred out.
module ray_sphere_intersect import rsi_pkg::*; #(
    parameter int SPHERE_COUNT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [271:0]        s_tdata,  // sphere_index, point_x, point_y, point_z,
                                          // dir_x, dir_y, dir_z, ray_t_min, ray_t_max, pad
    input  logic                s_tuser,  // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,  // hit_t
    output logic                m_tuser,  // hit
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data
);
    logic [RADIUS_W-1:0] radius_reg;
    logic [FIFO_AW:0]    pending_reg, pending_next;
    logic                s_xfer, m_xfer;

    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] dir [3];

    logic              q_valid;
    rsi_sq_tag_t       q_tag;
    logic [DISC_W-1:0] q_disc;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    rsi_sq_tag_t       sq_tag;

    // Root stage registers.
    logic               r_valid_reg;
    rsi_side_t          r_side_reg;
    logic [DIV_W-1:0]   r_q2_mag_reg, r_c2_reg, r_a2_reg;
    logic               r_q2_neg_reg, r_c_neg_reg, r_zero_reg;
    logic signed [52:0] q2;
    logic signed [52:0] b53, s53;
    logic [49:0]        c_mag;

    logic                   d0_valid, d1_valid;
    logic signed [QT_W-1:0] t0, t1;
    rsi_side_t              d0_side;
    logic                   d1_zero;

    logic                   f1_valid_reg, f2_valid_reg;
    rsi_side_t              f1_side_reg;
    logic signed [QT_W-1:0] lo_reg, hi_reg;
    rsi_result_t            f2_res_reg, f2_next;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // Radius register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Credit count: items accepted whose results are not yet transferred.
    assign pending_next = pending_reg + (FIFO_AW+1)'(s_xfer) - (FIFO_AW+1)'(m_xfer);
    assign s_tready     = pending_reg < (FIFO_AW+1)'(FIFO_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Input unpacking.
    assign pt[0]  = s_tdata[41:10];
    assign pt[1]  = s_tdata[73:42];
    assign pt[2]  = s_tdata[105:74];
    assign dir[0] = s_tdata[137:106];
    assign dir[1] = s_tdata[169:138];
    assign dir[2] = s_tdata[201:170];

    rsi_quad #(.SPHERE_COUNT(SPHERE_COUNT)) u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_xfer),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_index  (s_tdata[9:0]),
        .in_point  (pt),
        .in_dir    (dir),
        .in_t_min  (s_tdata[233:202]),
        .in_t_max  (s_tdata[265:234]),
        .radius    (radius_reg),
        .out_valid (q_valid),
        .out_tag   (q_tag),
        .out_disc  (q_disc)
    );

    rsi_sqrt #(.RAD_W(DISC_W), .TAG_W($bits(rsi_sq_tag_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_rad    (q_disc),
        .in_tag    (q_tag),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // Stable root form: q2 = -(b + sgn(b) s), and the divider operands.
    assign b53   = 53'(sq_tag.coef.b);
    assign s53   = signed'({2'b00, sq_root});
    assign q2    = sq_tag.coef.b[BC_W-1] ? (s53 - b53) : -(b53 + s53);
    assign c_mag = sq_tag.coef.c[BC_W-1] ? 50'(-sq_tag.coef.c) : 50'(sq_tag.coef.c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else begin
            r_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        r_side_reg   <= sq_tag.side;
        r_q2_neg_reg <= q2[52];
        r_q2_mag_reg <= q2[52] ? DIV_W'(-q2) : DIV_W'(q2);
        r_zero_reg   <= q2 == '0;
        r_c_neg_reg  <= sq_tag.coef.c[BC_W-1];
        r_c2_reg     <= DIV_W'({c_mag, 1'b0});
        r_a2_reg     <= DIV_W'({sq_tag.coef.a, 1'b0});
    end

    // t0 = q2 / 2a and t1 = 2c / q2.
    rsi_div #(.N_W(DIV_W), .D_W(DIV_W), .TAG_W($bits(rsi_side_t))) u_div0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid_reg),
        .in_num    (r_q2_mag_reg),
        .in_den    (r_a2_reg),
        .in_neg    (r_q2_neg_reg),
        .in_tag    (r_side_reg),
        .out_valid (d0_valid),
        .out_q     (t0),
        .out_tag   (d0_side)
    );

    rsi_div #(.N_W(DIV_W), .D_W(DIV_W), .TAG_W(1)) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid_reg),
        .in_num    (r_c2_reg),
        .in_den    (r_q2_mag_reg),
        .in_neg    (r_c_neg_reg ^ r_q2_neg_reg),
        .in_tag    (r_zero_reg),
        .out_valid (d1_valid),
        .out_q     (t1),
        .out_tag   (d1_zero)
    );

    // Sort the roots; a zero q2 gives two zero roots.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= d0_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_side_reg <= d0_side;
        if (d1_zero) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else if (t0 > t1) begin
            lo_reg <= t1;
            hi_reg <= t0;
        end else begin
            lo_reg <= t0;
            hi_reg <= t1;
        end
    end

    // Range test, root choice and saturation.
    always_comb begin
        logic signed [QT_W-1:0] tmin, tmax, pick;
        logic                   miss;
        tmin = QT_W'(f1_side_reg.t_min);
        tmax = QT_W'(f1_side_reg.t_max);
        miss = !f1_side_reg.live || (lo_reg >= tmax) || (hi_reg <= tmin);
        pick = (lo_reg > tmin) ? lo_reg : hi_reg;
        f2_next.hit = !miss;
        if (miss) begin
            f2_next.hit_t = f1_side_reg.t_max;
        end else if (pick > T_MAX32) begin
            f2_next.hit_t = T_MAX32[31:0];
        end else if (pick < T_MIN32) begin
            f2_next.hit_t = T_MIN32[31:0];
        end else begin
            f2_next.hit_t = pick[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        f2_res_reg <= f2_next;
    end

    rsi_result_t m_res;

    rsi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_valid  (f2_valid_reg),
        .wr_data   (f2_res_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tuser = m_res.hit;
    assign m_tdata = m_res.hit_t;

    // Credit count stays within the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    // A result is offered only for an accepted item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("result offered with no item pending");

    // Both dividers run in lockstep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        d0_valid == d1_valid)
        else $error("divider lanes out of step");

    // A radius write lands in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> radius_reg == $past(cfg_wr_data))
        else $error("radius write lost");

endmodule
